FILE: hw/rtl/rdmg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rdmg_pkg;

  localparam int COUNT_W = 16;
  localparam int SEED_W = 31;
  localparam int SIZE_W = 16;
  localparam int THRESH_W = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY = 2'd2;

  localparam logic [SEED_W-1:0] SEED_RESET = 31'd291;
  localparam logic [SIZE_W-1:0] MAP_SIZE_RESET = 16'd16;
  localparam logic [THRESH_W-1:0] DENSITY_RESET = 32'h8000_0000;

  localparam logic [31:0] RNG_INIT1 = 32'h0000_0234;
  localparam logic [31:0] RNG_INIT2 = 32'h0000_0345;
  localparam logic [31:0] RNG_INIT3 = 32'h0000_0456;

  localparam logic [7:0] CH_FREE = 8'd111;
  localparam logic [7:0] CH_BLOCK = 8'd46;
  localparam logic [7:0] CH_NL = 8'd10;

  typedef struct packed {
    logic [SEED_W-1:0]   seed;
    logic [SIZE_W-1:0]   map_size;
    logic [THRESH_W-1:0] density_threshold;
  } cfg_t;

  // front-to-back queue head
  typedef struct packed {
    logic valid;
    logic restart;
  } req_t;

  typedef struct packed {
    logic [7:0] map_char;
    logic       last_of_map;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rdmg_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rdmg_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic          in_restart,
  output logic               full,
  output rdmg_pkg::req_t     req,
  input  wire logic          req_take
);
  import rdmg_pkg::*;

  logic [1:0] slot_r;
  logic [1:0] slot_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign full = (cnt_r == 2'd2);
  assign do_wr = push && !full;
  assign do_rd = req_take && (cnt_r != 2'd0);

  assign req = '{valid: (cnt_r != 2'd0), restart: slot_r[rd_ptr_r]};

  always_comb begin
    slot_nxt = slot_r;
    if (do_wr) begin
      slot_nxt[wr_ptr_r] = in_restart;
    end
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt = cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("front queue count overflow");

  a_no_wr_full: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !do_rd) |=> cnt_r == 2'd2) else $error("front queue lost a slot");

  a_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && !do_wr) |=> cnt_r == 2'd0) else $error("front queue invented item");

endmodule

`default_nettype wire

FILE: hw/rtl/rdmg_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rdmg_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rdmg_pkg::cfg_t cfg,
  input  wire rdmg_pkg::req_t req,
  output logic                req_take,
  output logic                empty,
  input  wire logic           pop,
  output logic [7:0]          out_map_char,
  output logic                out_last_of_map
);
  import rdmg_pkg::*;

  logic [31:0] w0_r, w1_r, w2_r, w3_r;
  logic [31:0] w0_nxt, w1_nxt, w2_nxt, w3_nxt;
  logic [COUNT_W-1:0] col_r, col_nxt;
  logic [COUNT_W-1:0] row_r, row_nxt;
  logic done_r, done_nxt;

  res_t       q_r [2];
  logic       q_wr_ptr_r, q_rd_ptr_r;
  logic [1:0] q_cnt_r;
  logic       emit;
  res_t       emit_res;
  logic       do_pop;

  logic [COUNT_W-1:0] size;
  logic [31:0] b0, b1, b2, b3, t, draw;
  logic [COUNT_W-1:0] row_inc;

  assign size = COUNT_W'(cfg.map_size);
  assign req_take = req.valid && (q_cnt_r != 2'd2);
  assign do_pop = pop && (q_cnt_r != 2'd0);
  assign empty = (q_cnt_r == 2'd0);
  assign out_map_char = q_r[q_rd_ptr_r].map_char;
  assign out_last_of_map = q_r[q_rd_ptr_r].last_of_map;

  always_comb begin
    w0_nxt = w0_r;
    w1_nxt = w1_r;
    w2_nxt = w2_r;
    w3_nxt = w3_r;
    col_nxt = col_r;
    row_nxt = row_r;
    done_nxt = done_r;
    emit = 1'b0;
    emit_res = '{map_char: CH_NL, last_of_map: 1'b0};

    // restart reloads the generator before this item's draw
    if (req.restart) begin
      b0 = {1'b0, cfg.seed};
      b1 = RNG_INIT1;
      b2 = RNG_INIT2;
      b3 = RNG_INIT3;
    end else begin
      b0 = w0_r;
      b1 = w1_r;
      b2 = w2_r;
      b3 = w3_r;
    end

    t = b3 ^ (b3 << 11);
    t = t ^ (t >> 8);
    draw = t ^ b0 ^ (b0 >> 19);
    row_inc = (req.restart ? '0 : row_r) + 1'b1;

    if (req_take) begin
      if (req.restart) begin
        w0_nxt = b0;
        w1_nxt = b1;
        w2_nxt = b2;
        w3_nxt = b3;
        col_nxt = '0;
        row_nxt = '0;
        done_nxt = 1'b0;
      end
      if (!(done_r && !req.restart) && size != '0) begin
        emit = 1'b1;
        w0_nxt = draw;
        w1_nxt = b0;
        w2_nxt = b1;
        w3_nxt = b2;
        if (!req.restart && col_r >= size) begin
          col_nxt = '0;
          row_nxt = row_inc;
          if (row_inc >= size) begin
            done_nxt = 1'b1;
            emit_res.last_of_map = 1'b1;
          end
        end else begin
          emit_res.map_char = (draw <= cfg.density_threshold) ? CH_FREE : CH_BLOCK;
          col_nxt = (req.restart ? '0 : col_r) + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      q_r[q_wr_ptr_r] <= emit_res;
    end
    if (!rst_n) begin
      w0_r <= {1'b0, SEED_RESET};
      w1_r <= RNG_INIT1;
      w2_r <= RNG_INIT2;
      w3_r <= RNG_INIT3;
      col_r <= '0;
      row_r <= '0;
      done_r <= 1'b0;
      q_wr_ptr_r <= 1'b0;
      q_rd_ptr_r <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      w0_r <= w0_nxt;
      w1_r <= w1_nxt;
      w2_r <= w2_nxt;
      w3_r <= w3_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      done_r <= done_nxt;
      if (emit) begin
        q_wr_ptr_r <= ~q_wr_ptr_r;
      end
      if (do_pop) begin
        q_rd_ptr_r <= ~q_rd_ptr_r;
      end
      q_cnt_r <= q_cnt_r + {1'b0, emit} - {1'b0, do_pop};
    end
  end

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3) else $error("result queue overflow");

  a_last_nl: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_res.last_of_map) |-> emit_res.map_char == CH_NL)
    else $error("last item is not a newline");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_res.last_of_map) |=> done_r)
    else $error("map not closed after last item");

endmodule

`default_nettype wire

FILE: hw/rtl/random_density_map_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// Streams a square text map: each accepted request item yields one character
// ('o', '.' or newline), drawn from a four-word xorshift generator, or nothing
// once the map is finished or when map_size is zero. A request with
// in_restart set reloads the generator from the seed register first. The
// block takes one item per clock and delivers at most one per clock while
// pop keeps the result queue from filling; a result shows on the out_ ports
// in the cycle after the back end takes its request, and can be popped then.
// That rate is set by the back end, which does one generator step, the
// threshold compare and row/column update in one combinational pass. Two-entry
// queues on the request and result sides let either side stall alone.
// Write configuration only while no request is in flight.
module random_density_map_generator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           in_restart,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [7:0]                          out_map_char,
  output logic                                out_last_of_map,
  input  wire logic                           cfg_we,
  input  wire logic [rdmg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rdmg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rdmg_pkg::*;

  cfg_t cfg_r;
  req_t req;
  logic req_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seed <= SEED_RESET;
      cfg_r.map_size <= MAP_SIZE_RESET;
      cfg_r.density_threshold <= DENSITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEED:     cfg_r.seed <= cfg_wdata[SEED_W-1:0];
        REG_MAP_SIZE: cfg_r.map_size <= cfg_wdata[SIZE_W-1:0];
        REG_DENSITY:  cfg_r.density_threshold <= cfg_wdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  rdmg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_restart (in_restart),
    .full       (full),
    .req        (req),
    .req_take   (req_take)
  );

  rdmg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .req             (req),
    .req_take        (req_take),
    .empty           (empty),
    .pop             (pop),
    .out_map_char    (out_map_char),
    .out_last_of_map (out_last_of_map)
  );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rdmg_pkg::*;

  localparam int SETTLE_CYCLES = 10;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1200;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int {POP_ALWAYS, POP_HALF, POP_SPARSE, POP_BURSTY} pop_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic                  in_restart = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [7:0]            out_map_char;
  logic                  out_last_of_map;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  random_density_map_generator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_restart      (in_restart),
    .empty           (empty),
    .pop             (pop),
    .out_map_char    (out_map_char),
    .out_last_of_map (out_last_of_map),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #5 clk = ~clk;

  // register shadow
  logic [SEED_W-1:0]   seed_q = SEED_RESET;
  logic [SIZE_W-1:0]   map_size_q = MAP_SIZE_RESET;
  logic [THRESH_W-1:0] thresh_q = DENSITY_RESET;

  // generator and map position shadow
  logic [31:0]        gen_w [4];
  logic [COUNT_W-1:0] col_q;
  logic [COUNT_W-1:0] row_q;
  bit                 map_finished;

  bit   pending_restart [$];
  res_t map_due [$];

  int n_items = 0;
  int n_chars = 0;
  int n_maps = 0;
  int n_cfg_writes = 0;
  int n_errors = 0;

  function automatic void reload_gen();
    gen_w[0] = {1'b0, seed_q};
    gen_w[1] = RNG_INIT1;
    gen_w[2] = RNG_INIT2;
    gen_w[3] = RNG_INIT3;
    col_q = '0;
    row_q = '0;
    map_finished = 1'b0;
  endfunction

  // one request item: optional reload, then at most one character
  function automatic void advance_map(bit restart);
    logic [31:0] t;
    logic [31:0] s;
    res_t        r;
    if (restart) reload_gen();
    if (map_finished || map_size_q == '0) return;
    t = gen_w[3];
    s = gen_w[0];
    gen_w[3] = gen_w[2];
    gen_w[2] = gen_w[1];
    gen_w[1] = s;
    t = t ^ (t << 11);
    t = t ^ (t >> 8);
    gen_w[0] = t ^ s ^ (s >> 19);
    if (col_q >= map_size_q) begin
      col_q = '0;
      row_q = row_q + 1'b1;
      r.map_char = CH_NL;
      r.last_of_map = (row_q >= map_size_q);
      if (r.last_of_map) begin
        map_finished = 1'b1;
        n_maps++;
      end
    end else begin
      r.map_char = (gen_w[0] <= thresh_q) ? CH_FREE : CH_BLOCK;
      r.last_of_map = 1'b0;
      col_q = col_q + 1'b1;
    end
    map_due.push_back(r);
    n_chars++;
  endfunction

  // driver: bursts of random length separated by random gaps
  int burst_left = 8;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        advance_map(in_restart);
        n_items++;
      end
      if (push && full) begin
        // hold the item until it is taken
      end else if (gap_left != 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_restart.size() != 0) begin
        push <= 1'b1;
        in_restart <= pending_restart.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: check each character against the oldest prediction
  pop_mode_e pop_mode = POP_ALWAYS;
  int        pop_cycle = 0;

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (map_due.size() == 0) begin
          $display("%0t: unexpected item, got char %0d last %0b",
                   $time, out_map_char, out_last_of_map);
          n_errors++;
        end else begin
          exp_r = map_due.pop_front();
          if (out_map_char !== exp_r.map_char) begin
            $display("%0t: map_char mismatch, expected %0d, got %0d",
                     $time, exp_r.map_char, out_map_char);
            n_errors++;
          end
          if (out_last_of_map !== exp_r.last_of_map) begin
            $display("%0t: last_of_map mismatch, expected %0b, got %0b",
                     $time, exp_r.last_of_map, out_last_of_map);
            n_errors++;
          end
        end
      end
      pop_cycle++;
      if (pop_cycle % 48 == 0) pop_mode = pop_mode_e'($urandom_range(0, 3));
      case (pop_mode)
        POP_ALWAYS: pop <= 1'b1;
        POP_HALF:   pop <= 1'($urandom_range(0, 1));
        POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
        default:    pop <= ((pop_cycle % 32) >= 20);
      endcase
    end
  end

  // watchdog: give up when outstanding work makes no progress
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) ||
          (pending_restart.size() == 0 && !push && map_due.size() == 0)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("FAIL random_density_map_generator");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_SEED:     seed_q = data[SEED_W-1:0];
      REG_MAP_SIZE: map_size_q = data[SIZE_W-1:0];
      REG_DENSITY:  thresh_q = data;
      default: ;
    endcase
    n_cfg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain: nothing queued, nothing predicted, then let item-free requests settle
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_restart.size() != 0 || push || map_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_items(input bit first_restart, input int count, input bit noisy);
    @(negedge clk);
    for (int i = 0; i < count; i++) begin
      if (i == 0) pending_restart.push_back(first_restart);
      else pending_restart.push_back(noisy && $urandom_range(0, 39) == 0);
    end
    wait_idle();
  endtask

  initial begin
    int          directed_items;
    int          pick;
    int          map_len;
    int          count;
    logic [15:0] size_pick;
    reload_gen();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, no restart
    run_items(1'b0, 4, 1'b0);

    // zero size: nothing comes out, with or without restart
    write_reg(REG_MAP_SIZE, 32'h0);
    run_items(1'b0, 1, 1'b0);
    run_items(1'b1, 1, 1'b0);

    // one-cell map, top seed, zero threshold; finished map stays silent
    write_reg(REG_SEED, 32'hFFFF_FFFF);
    write_reg(REG_MAP_SIZE, 32'h1);
    write_reg(REG_DENSITY, 32'h0);
    run_items(1'b1, 3, 1'b0);
    run_items(1'b1, 2, 1'b0);

    // zero seed, full-scale threshold, one request past the end
    write_reg(REG_SEED, 32'h0);
    write_reg(REG_MAP_SIZE, 32'h2);
    write_reg(REG_DENSITY, 32'hFFFF_FFFF);
    run_items(1'b1, 7, 1'b0);

    // largest size, then shrink mid-map; seed and spare index written mid-map
    write_reg(REG_MAP_SIZE, 32'hFFFF_FFFF);
    run_items(1'b1, 4, 1'b0);
    write_reg(REG_SEED, 32'h1234_5678);
    write_reg(REG_SPARE, 32'hA5A5_A5A5);
    write_reg(REG_MAP_SIZE, 32'h2);
    run_items(1'b0, 4, 1'b0);

    directed_items = n_items;
    while (n_items - directed_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        pick = $urandom_range(0, 9);
        write_reg(REG_SEED, (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom());
      end
      if ($urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) size_pick = 16'd0;
        else if (pick < 80) size_pick = 16'($urandom_range(1, 5));
        else if (pick < 96) size_pick = 16'($urandom_range(6, 12));
        else size_pick = 16'($urandom_range(13, 20));
        write_reg(REG_MAP_SIZE, {16'($urandom()), size_pick});
      end
      if ($urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 9);
        write_reg(REG_DENSITY, (pick < 2) ? 32'h0 : (pick < 4) ? 32'hFFFF_FFFF : $urandom());
      end
      if ($urandom_range(0, 19) == 0) write_reg(REG_SPARE, $urandom());

      map_len = int'(map_size_q) * (int'(map_size_q) + 1);
      if (map_len == 0) count = $urandom_range(1, 3);
      else if ($urandom_range(0, 5) == 0) count = $urandom_range(1, map_len);
      else count = map_len + $urandom_range(0, 2);
      run_items($urandom_range(0, 9) < 8, count, 1'b1);
    end

    $display("Run covered %0d request items, %0d map characters, %0d completed maps,",
             n_items, n_chars, n_maps);
    $display("  %0d register writes, %0d mismatches", n_cfg_writes, n_errors);
    if (n_errors == 0 && map_due.size() == 0) begin
      $display("PASS random_density_map_generator");
    end else begin
      $display("FAIL random_density_map_generator");
    end
    $finish;
  end

endmodule
